// ===== design/assert_macros.svh =====
// Assertion helpers for the rotation matrix to quaternion block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RMQ_ASSERT_CLK(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
`define RMQ_ASSERT(label, prop) `RMQ_ASSERT_CLK(label, clk_i, rst_ni, prop)
`else
`define RMQ_ASSERT_CLK(label, clk, rstn, prop)
`define RMQ_ASSERT(label, prop)
`endif
`endif

// ===== design/rmq_pkg.sv =====
package rmq_pkg;

  localparam int unsigned FRAC_BITS_DEF = 14;
  localparam int unsigned Q_BITS        = 16;
  localparam int unsigned NUM_W         = 17;

  // component slots
  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;
  localparam logic [1:0] COMP_W = 2'd3;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } rmq_in_t;

  typedef struct packed {
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic               invalid;
  } rmq_out_t;

  // per-item control carried beside the arithmetic
  typedef struct packed {
    logic                        inv;
    logic [1:0]                  idx;
    logic [3:0]                  neg;
    logic [3:0][NUM_W-1:0]       mag;
  } rmq_side_t;

  // next axis in cyclic order
  function automatic logic [1:0] axis_next(input logic [1:0] a);
    logic [1:0] r;
    case (a)
      COMP_X:  r = COMP_Y;
      COMP_Y:  r = COMP_Z;
      default: r = COMP_X;
    endcase
    return r;
  endfunction

  // matrix element by row and column
  function automatic logic signed [15:0] elem(input rmq_in_t m, input logic [1:0] r,
                                              input logic [1:0] c);
    logic signed [15:0] e;
    case ({r, c})
      4'b0000: e = m.m00;
      4'b0001: e = m.m01;
      4'b0010: e = m.m02;
      4'b0100: e = m.m10;
      4'b0101: e = m.m11;
      4'b0110: e = m.m12;
      4'b1000: e = m.m20;
      4'b1001: e = m.m21;
      default: e = m.m22;
    endcase
    return e;
  endfunction

endpackage

// ===== design/rmq_sqrt_pipe.sv =====
module rmq_sqrt_pipe import rmq_pkg::*; #(
  parameter int unsigned RW = 23
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*RW-1:0] v_i,
  output logic [RW-1:0]   root_o,
  output logic [RW+1:0]   rem_o
);

  logic [RW+1:0]   rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [2*RW-1:0] v_q    [RW];
  logic [RW+1:0]   rem_d  [RW];
  logic [RW-1:0]   root_d [RW];
  logic [2*RW-1:0] v_d    [RW];

  // one root bit per stage, two radicand bits consumed
  always_comb begin
    logic [RW+3:0]   tmp;
    logic [RW+3:0]   trl;
    logic [RW+1:0]   sr;
    logic [RW-1:0]   so;
    logic [2*RW-1:0] sv;
    for (int t = 0; t < RW; t++) begin
      if (t == 0) begin
        sr = '0;
        so = '0;
        sv = v_i;
      end else begin
        sr = rem_q[t-1];
        so = root_q[t-1];
        sv = v_q[t-1];
      end
      tmp = {sr, sv[2*RW-1 -: 2]};
      trl = (RW+4)'({so, 2'b01});
      if (tmp >= trl) begin
        rem_d[t]  = (RW+2)'(tmp - trl);
        root_d[t] = {so[RW-2:0], 1'b1};
      end else begin
        rem_d[t]  = (RW+2)'(tmp);
        root_d[t] = {so[RW-2:0], 1'b0};
      end
      v_d[t] = sv << 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      v_q    <= v_d;
    end
  end

  assign root_o = root_q[RW-1];
  assign rem_o  = rem_q[RW-1];

endmodule

// ===== design/rmq_div_pipe.sv =====
module rmq_div_pipe import rmq_pkg::*; #(
  parameter int unsigned WW = 52
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [WW-1:0]     n_i,
  input  logic [WW-1:0]     d_i,
  output logic [Q_BITS-1:0] q_o,
  output logic              ovf_o
);

  localparam int unsigned ST = Q_BITS + 1;

  logic [WW-1:0]     rem_q [ST];
  logic [WW-1:0]     den_q [ST];
  logic [Q_BITS-1:0] quo_q [ST];
  logic              ovf_q [ST];
  logic [WW-1:0]     rem_d [ST];
  logic [WW-1:0]     den_d [ST];
  logic [Q_BITS-1:0] quo_d [ST];
  logic              ovf_d [ST];

  // first stage flags a quotient past the result width, then one bit per stage
  always_comb begin
    logic [WW-1:0] sh;
    rem_d[0] = n_i;
    den_d[0] = d_i;
    quo_d[0] = '0;
    ovf_d[0] = (n_i >= (d_i << Q_BITS));
    for (int t = 1; t < ST; t++) begin
      sh       = den_q[t-1] << (Q_BITS - t);
      den_d[t] = den_q[t-1];
      ovf_d[t] = ovf_q[t-1];
      if (rem_q[t-1] >= sh) begin
        rem_d[t] = rem_q[t-1] - sh;
        quo_d[t] = quo_q[t-1] | (Q_BITS'(1) << (Q_BITS - t));
      end else begin
        rem_d[t] = rem_q[t-1];
        quo_d[t] = quo_q[t-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      den_q <= den_d;
      quo_q <= quo_d;
      ovf_q <= ovf_d;
    end
  end

  assign q_o   = quo_q[ST-1];
  assign ovf_o = ovf_q[ST-1];

endmodule

// ===== design/rotation_matrix_to_quaternion_core.sv =====
// Rotation matrix to unit quaternion by Shepperd's method, fixed point with
// FRAC_BITS fraction bits. One beat in, one beat out, one item per cycle
// sustained unless a result beat is stalled. The square root gives one bit per
// stage, RW = ceil((FRAC_BITS + max(FRAC_BITS,17) + 1) / 2) bits in all; the
// three quotients take 17 stages, the first flagging overflow and the rest one
// bit each. A stall on a held result freezes the whole pipeline. A matrix whose
// radicand is not positive yields the identity quaternion with invalid set.
`include "assert_macros.svh"
module rotation_matrix_to_quaternion_core import rmq_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  rmq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output rmq_out_t out_data_o
);

  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned RADW = ((F > 17) ? F : 17) + 2;
  localparam int unsigned VW   = RADW - 1 + F;
  localparam int unsigned RW   = (VW + 1) / 2;
  localparam int unsigned WW   = ((F > RW) ? F : RW) + 19;
  localparam int unsigned DV   = Q_BITS + 1;
  localparam int unsigned LAT  = RW + DV + 6;
  localparam logic signed [RADW-1:0] OneRad = RADW'(1) << F;
  localparam logic signed [15:0] IdentW = (F >= 15) ? 16'sd32767 : 16'(1 << F);

  logic adv;
  logic [LAT-1:0] vld_q;

  // advance everything unless the result beat is held
  assign adv        = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // stage 1: capture input
  rmq_in_t in_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q <= in_data_i;
    end
  end

  // stage 2: trace and dominant axis
  rmq_in_t mat2_q;
  logic signed [17:0] tr_d, tr2_q;
  logic pos2_q;
  logic [1:0] axis_d, axis2_q;

  always_comb begin
    tr_d   = 18'(in_q.m00) + 18'(in_q.m11) + 18'(in_q.m22);
    axis_d = COMP_X;
    if (in_q.m11 > in_q.m00) axis_d = COMP_Y;
    if (in_q.m22 > elem(in_q, axis_d, axis_d)) axis_d = COMP_Z;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mat2_q  <= in_q;
      tr2_q   <= tr_d;
      pos2_q  <= (tr_d > 0);
      axis2_q <= axis_d;
    end
  end

  // stage 3: radicand and numerators
  logic signed [RADW-1:0]  rad;
  logic signed [NUM_W-1:0] num [4];
  rmq_side_t side_d, side3_q;
  logic [RADW-2:0] rad3_q;

  always_comb begin
    logic [1:0] ii, jj, kk;
    ii = axis2_q;
    jj = axis_next(ii);
    kk = axis_next(jj);
    for (int c = 0; c < 4; c++) num[c] = '0;
    if (pos2_q) begin
      rad        = RADW'(tr2_q) + OneRad;
      side_d.idx = COMP_W;
      num[COMP_X] = NUM_W'(mat2_q.m21) - NUM_W'(mat2_q.m12);
      num[COMP_Y] = NUM_W'(mat2_q.m02) - NUM_W'(mat2_q.m20);
      num[COMP_Z] = NUM_W'(mat2_q.m10) - NUM_W'(mat2_q.m01);
    end else begin
      rad = RADW'(elem(mat2_q, ii, ii)) - RADW'(elem(mat2_q, jj, jj))
          - RADW'(elem(mat2_q, kk, kk)) + OneRad;
      side_d.idx  = ii;
      num[COMP_W] = NUM_W'(elem(mat2_q, kk, jj)) - NUM_W'(elem(mat2_q, jj, kk));
      num[jj]     = NUM_W'(elem(mat2_q, jj, ii)) + NUM_W'(elem(mat2_q, ii, jj));
      num[kk]     = NUM_W'(elem(mat2_q, kk, ii)) + NUM_W'(elem(mat2_q, ii, kk));
    end
    side_d.inv = !pos2_q && (rad <= 0);
    for (int c = 0; c < 4; c++) begin
      side_d.neg[c] = num[c][NUM_W-1];
      side_d.mag[c] = num[c][NUM_W-1] ? NUM_W'(-num[c]) : NUM_W'(num[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side3_q <= side_d;
      rad3_q  <= side_d.inv ? '0 : (RADW-1)'(rad);
    end
  end

  // square root of radicand scaled by one
  logic [RW-1:0] root;
  logic [RW+1:0] rem;

  rmq_sqrt_pipe #(.RW(RW)) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .v_i    ((2*RW)'({rad3_q, {F{1'b0}}})),
    .root_o (root),
    .rem_o  (rem)
  );

  rmq_side_t side_sq_q [RW];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_sq_q[0] <= side3_q;
      for (int t = 1; t < RW; t++) side_sq_q[t] <= side_sq_q[t-1];
    end
  end

  // round root to nearest
  logic [RW:0] s1_q;
  rmq_side_t side_r1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q      <= (RW+1)'(root) + (RW+1)'((RW+2)'(rem) > (RW+2)'(root));
      side_r1_q <= side_sq_q[RW-1];
    end
  end

  // dividend, divisor and the rooted half
  logic [WW-1:0] n2_q [4];
  logic [WW-1:0] d2_q;
  logic [RW-1:0] half2_q;
  rmq_side_t side_r2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        n2_q[c] <= (WW'(side_r1_q.mag[c]) << (F + 1)) + (WW'(s1_q) << 1);
      end
      d2_q      <= WW'(s1_q) << 2;
      half2_q   <= RW'(((RW+2)'(s1_q) + (RW+2)'(1)) >> 1);
      side_r2_q <= side_r1_q;
    end
  end

  // four quotient lanes, the rooted slot is discarded
  logic [Q_BITS-1:0] quo [4];
  logic              ovf [4];
  for (genvar c = 0; c < 4; c++) begin : g_div
    rmq_div_pipe #(.WW(WW)) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .n_i   (n2_q[c]),
      .d_i   (d2_q),
      .q_o   (quo[c]),
      .ovf_o (ovf[c])
    );
  end

  rmq_side_t     side_dv_q [DV];
  logic [RW-1:0] half_dv_q [DV];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_dv_q[0] <= side_r2_q;
      half_dv_q[0] <= half2_q;
      for (int t = 1; t < DV; t++) begin
        side_dv_q[t] <= side_dv_q[t-1];
        half_dv_q[t] <= half_dv_q[t-1];
      end
    end
  end

  // sign, saturate and assemble the result
  rmq_out_t out_d, out_q;
  always_comb begin
    logic signed [15:0] qv [4];
    rmq_side_t sd;
    sd = side_dv_q[DV-1];
    for (int c = 0; c < 4; c++) begin
      if (2'(c) == sd.idx) begin
        qv[c] = ((RW+32)'(half_dv_q[DV-1]) > (RW+32)'(32767)) ? 16'sd32767
              : 16'(half_dv_q[DV-1]);
      end else if (sd.neg[c]) begin
        qv[c] = (ovf[c] || (quo[c] > 16'd32768)) ? -16'sd32768 : 16'(-quo[c]);
      end else begin
        qv[c] = (ovf[c] || (quo[c] > 16'd32767)) ? 16'sd32767 : 16'(quo[c]);
      end
    end
    if (sd.inv) begin
      out_d = '{qx: '0, qy: '0, qz: '0, qw: IdentW, invalid: 1'b1};
    end else begin
      out_d = '{qx: qv[COMP_X], qy: qv[COMP_Y], qz: qv[COMP_Z], qw: qv[COMP_W],
                invalid: 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[LAT-1];
  assign out_data_o  = out_q;

  // checks
  `RMQ_ASSERT(a_inv_identity, (out_valid_o && out_data_o.invalid) |-> (out_data_o.qx == 0 && out_data_o.qy == 0 && out_data_o.qz == 0 && out_data_o.qw == IdentW))
  `RMQ_ASSERT(a_root_positive, (out_valid_o && !out_data_o.invalid) |-> (out_data_o.qx > 0 || out_data_o.qy > 0 || out_data_o.qz > 0 || out_data_o.qw > 0))
  `RMQ_ASSERT(a_stall_needs_beat, in_stall_o |-> out_valid_o)

endmodule

// ===== tb/sv/tb_rotation_matrix_to_quaternion_core.sv =====
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion_core;
  import rmq_pkg::*;

  localparam int unsigned FB         = FRAC_BITS_DEF;
  localparam int          WDOG_LIMIT = 3000;
  localparam int          HOLD_CYC   = 400;
  localparam int          DRAIN_CYC  = 100;

  // Expected quaternion store and checker
  class quat_scoreboard;
    rmq_out_t expected_quats[$];
    int       mismatches;

    // Round-to-nearest integer square root
    static function longint unsigned root_nearest(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      if (v > res) res++;
      return res;
    endfunction

    // n * 2^FB / d, ties away from zero
    static function longint scaled_quot(longint n, longint unsigned d);
      longint unsigned mag;
      longint unsigned qq;
      mag = (n < 0) ? longint'(-n) : n;
      qq  = ((mag << FB) * 2 + d) / (2 * d);
      return (n < 0) ? -longint'(qq) : longint'(qq);
    endfunction

    static function logic signed [15:0] clamp16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    static function rmq_out_t quat_of_matrix(rmq_in_t a);
      longint          m[3][3];
      longint          q[4];
      longint          one, tr, rad;
      longint unsigned s;
      int              i, j, k;
      rmq_out_t        r;
      one = longint'(1) << FB;
      m[0][0] = a.m00; m[0][1] = a.m01; m[0][2] = a.m02;
      m[1][0] = a.m10; m[1][1] = a.m11; m[1][2] = a.m12;
      m[2][0] = a.m20; m[2][1] = a.m21; m[2][2] = a.m22;
      tr = m[0][0] + m[1][1] + m[2][2];
      r.invalid = 1'b0;
      if (tr > 0) begin
        rad  = tr + one;
        s    = root_nearest(longint'(rad) << FB);
        q[3] = (s + 1) >> 1;
        q[0] = scaled_quot(m[2][1] - m[1][2], 2 * s);
        q[1] = scaled_quot(m[0][2] - m[2][0], 2 * s);
        q[2] = scaled_quot(m[1][0] - m[0][1], 2 * s);
      end else begin
        // largest diagonal picks the axis, first wins on ties
        i = 0;
        if (m[1][1] > m[0][0]) i = 1;
        if (m[2][2] > m[i][i]) i = 2;
        j = (i + 1) % 3;
        k = (j + 1) % 3;
        rad = m[i][i] - m[j][j] - m[k][k] + one;
        if (rad <= 0) begin
          r.qx = '0; r.qy = '0; r.qz = '0;
          r.qw = clamp16(one);
          r.invalid = 1'b1;
          return r;
        end
        s    = root_nearest(longint'(rad) << FB);
        q[i] = (s + 1) >> 1;
        q[3] = scaled_quot(m[k][j] - m[j][k], 2 * s);
        q[j] = scaled_quot(m[j][i] + m[i][j], 2 * s);
        q[k] = scaled_quot(m[k][i] + m[i][k], 2 * s);
      end
      r.qx = clamp16(q[0]);
      r.qy = clamp16(q[1]);
      r.qz = clamp16(q[2]);
      r.qw = clamp16(q[3]);
      return r;
    endfunction

    function void note_matrix(rmq_in_t a);
      expected_quats.push_back(quat_of_matrix(a));
    endfunction

    function void check_quat(rmq_out_t got);
      rmq_out_t exp_q;
      if (expected_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected beat %h", got);
        return;
      end
      exp_q = expected_quats.pop_front();
      if (got.qx !== exp_q.qx || got.qy !== exp_q.qy || got.qz !== exp_q.qz ||
          got.qw !== exp_q.qw || got.invalid !== exp_q.invalid) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: exp x=%0d y=%0d z=%0d w=%0d inv=%0b",
                   exp_q.qx, exp_q.qy, exp_q.qz, exp_q.qw, exp_q.invalid,
                   " got x=%0d y=%0d z=%0d w=%0d inv=%0b",
                   got.qx, got.qy, got.qz, got.qw, got.invalid);
      end
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  rmq_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  rmq_out_t out_data_o;

  quat_scoreboard sb = new();
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  rotation_matrix_to_quaternion_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Watch both channels and the watchdog
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) sb.note_matrix(in_data_i);
    if (out_valid_o && !out_stall_i) sb.check_quat(out_data_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Drive the receiver stall: long hold on request, random bursts while idling is on
  initial begin
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  // Offer one beat, hold it until taken, then maybe leave a gap
  task automatic send_matrix(rmq_in_t a);
    in_valid_i <= 1'b1;
    in_data_i  <= a;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_quats.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_elem(int mode);
    logic [15:0] pick[5] = '{16'h8000, 16'h7fff, 16'h0000, 16'h4000, 16'hc000};
    case (mode)
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 32768) - 16384);
      default: return pick[$urandom_range(0, 4)];
    endcase
  endfunction

  // Random elements, or a signed axis permutation scaled to one plus a little noise
  function automatic rmq_in_t rand_matrix();
    rmq_in_t     a;
    logic [15:0] e[9];
    int          mode, p0, p1, p2;
    mode = $urandom_range(0, 3);
    if (mode == 3) begin
      p0 = $urandom_range(0, 2);
      p1 = (p0 + $urandom_range(1, 2)) % 3;
      p2 = 3 - p0 - p1;
      foreach (e[n]) e[n] = 16'($urandom_range(0, 400) - 200);
      e[p0]     = 16'(e[p0]     + ($urandom_range(0, 1) ? 16384 : -16384));
      e[3 + p1] = 16'(e[3 + p1] + ($urandom_range(0, 1) ? 16384 : -16384));
      e[6 + p2] = 16'(e[6 + p2] + ($urandom_range(0, 1) ? 16384 : -16384));
    end else begin
      foreach (e[n]) e[n] = rand_elem(mode);
    end
    a = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    return a;
  endfunction

  function automatic rmq_in_t mat(int a0, int a1, int a2, int a3, int a4,
                                  int a5, int a6, int a7, int a8);
    rmq_in_t a;
    a = {a0[15:0], a1[15:0], a2[15:0], a3[15:0], a4[15:0],
         a5[15:0], a6[15:0], a7[15:0], a8[15:0]};
    return a;
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identity, axis flips, ties, extremes
    send_matrix(mat(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
    send_matrix(mat(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
    send_matrix(mat(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
    send_matrix(mat(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
    send_matrix(mat(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_matrix(mat(-8192, 0, 0, 0, -8192, 0, 0, 0, -8192));
    send_matrix(mat(0, -16384, 0, 16384, 0, 0, 0, 0, 16384));
    send_matrix(mat(0, 16384, 0, 16384, 0, 0, 0, 0, -16384));
    send_matrix(mat(16384, 5, 7, 9, 16384, 3, 1, 2, -32768));
    send_matrix(mat(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_matrix(mat(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_matrix(mat(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768));
    send_matrix(mat(1, 32767, -32768, -32768, 0, 32767, 32767, -32768, -1));
    send_matrix(mat(-32768, 32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
    send_matrix(mat(11585, -11585, 0, 11585, 11585, 0, 0, 0, 16384));
    send_matrix(mat(16384, -32768, 32767, 32767, -16384, -32768, -32768, 32767, 0));
    wait_drain();

    // Random with idling on both sides
    repeat (130) send_matrix(rand_matrix());

    // Hold the receiver off so the pipeline fills and backs up
    hold_req = 1'b1;
    repeat (90) send_matrix(rand_matrix());
    wait_drain();

    repeat (50) send_matrix(rand_matrix());

    // Final stretch at full rate
    idle_on = 1'b0;
    repeat (130) send_matrix(rand_matrix());
    wait_drain();
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.expected_quats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== rotation_matrix_to_quaternion_core.f =====
+incdir+design
design/rmq_pkg.sv
design/rmq_sqrt_pipe.sv
design/rmq_div_pipe.sv
design/rotation_matrix_to_quaternion_core.sv
tb/sv/tb_rotation_matrix_to_quaternion_core.sv
